### rtl/itc_pkg.sv
package itc_pkg;

  localparam int unsigned StatusDelayDepthDef = 4;

  localparam int unsigned InDataW  = 72;
  localparam int unsigned InUserW  = 5;
  localparam int unsigned OutDataW = 64;

  localparam logic [31:0] CmpbMask     = 32'h00ff_ffff;
  localparam logic [31:0] CauseForced  = 32'h0000_00c0;
  localparam logic [31:0] CmpaKeepMask = 32'h0000_ffef;
  localparam logic [31:0] CmpbKeepMask = 32'h0000_ffdf;
  localparam logic [31:0] CauseCmpa    = 32'h0000_0010;
  localparam logic [31:0] CauseCmpb    = 32'h0000_0020;

  typedef enum logic [1:0] {
    FuncTick   = 2'd0,
    FuncRead   = 2'd1,
    FuncWrite  = 2'd2,
    FuncRetire = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    RegVector   = 3'd0,
    RegCause    = 3'd1,
    RegMask     = 3'd2,
    RegStatus   = 3'd3,
    RegEpc      = 3'd4,
    RegCounter  = 3'd5,
    RegCompare  = 3'd6,
    RegCompare2 = 3'd7
  } reg_sel_e;

  typedef struct packed {
    logic [31:0] handler_pc;
    logic        irq_taken;
    logic [31:0] read_data;
  } result_t;

endpackage

### rtl/itc_out_buf.sv
module itc_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  itc_pkg::result_t  push_data_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              pop_ready_i,
  output itc_pkg::result_t  pop_data_o
);
  import itc_pkg::*;

  // Two-entry queue: slot 0 is the head shown on the output.
  result_t     slot0_q, slot0_d;
  result_t     slot1_q, slot1_d;
  logic [1:0]  count_q, count_d;
  logic        pop;

  assign ready_o    = (count_q != 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop        = valid_o && pop_ready_i;
  assign pop_data_o = slot0_q;

  always_comb begin
    count_d = count_q + {1'b0, push_i} - {1'b0, pop};
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (pop) begin
      slot0_d = (count_q == 2'd2) ? slot1_q : push_data_i;
    end else if (count_q == 2'd0) begin
      slot0_d = push_data_i;
    end
    if (push_i && count_q == 2'd1 && !pop) begin
      slot1_d = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

### rtl/irq_timer_controller.sv
// Interrupt and timer controller. Every input item (tick, register read, register write or
// instruction retire) is handled in the cycle it is accepted, and one result item per input
// item is registered into the output queue. An item can be accepted every cycle; a two-entry
// output queue lets the block take one more item while a result waits, so the input stalls
// only when two results are held back by the output side. On a tick the counter advances, the
// cause bits are refreshed and, unless stalled, interrupt entry is checked; entry saves the
// next pc, clears the status with its delay line and reports the vector address.
module irq_timer_controller #(
  parameter int unsigned STATUS_DELAY_DEPTH = itc_pkg::StatusDelayDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // write_value [31:0], noc_irq [32], stall_req [33], next_pc [65:34], zero [71:66]
  input  logic [itc_pkg::InDataW-1:0]  s_axis_tdata_i,
  // func [1:0], reg_select [4:2]
  input  logic [itc_pkg::InUserW-1:0]  s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // read_data [31:0], handler_pc [63:32]
  output logic [itc_pkg::OutDataW-1:0] m_axis_tdata_o,
  // irq_taken [0]
  output logic                         m_axis_tuser_o
);
  import itc_pkg::*;

  localparam int unsigned Tail = STATUS_DELAY_DEPTH - 1;

  logic [31:0] count_q,  count_d;
  logic [31:0] cmpa_q,   cmpa_d;
  logic [31:0] cmpb_q,   cmpb_d;
  logic [31:0] cause_q,  cause_d;
  logic [31:0] mask_q,   mask_d;
  logic [31:0] status_q, status_d;
  logic [31:0] epc_q,    epc_d;
  logic [31:0] vector_q, vector_d;
  logic [31:0] line_q [STATUS_DELAY_DEPTH];
  logic [31:0] line_d [STATUS_DELAY_DEPTH];

  func_e       func;
  reg_sel_e    sel;
  logic [31:0] wval;
  logic        irq_line;
  logic        stall;
  logic [31:0] npc;
  logic        accept;
  logic [31:0] count_inc;
  logic [31:0] tick_cause;
  logic        taken;
  result_t     res;
  result_t     out_res;

  assign func     = func_e'(s_axis_tuser_i[1:0]);
  assign sel      = reg_sel_e'(s_axis_tuser_i[4:2]);
  assign wval     = s_axis_tdata_i[31:0];
  assign irq_line = s_axis_tdata_i[32];
  assign stall    = s_axis_tdata_i[33];
  assign npc      = s_axis_tdata_i[65:34];
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;

  assign count_inc = count_q + 32'd1;

  always_comb begin
    tick_cause = cause_q;
    if ((cmpb_q & CmpbMask) == (count_inc & CmpbMask)) begin
      tick_cause = tick_cause | CauseCmpb;
    end
    if (cmpa_q == count_inc) begin
      tick_cause = tick_cause | CauseCmpa;
    end
    tick_cause[3] = ~count_inc[16];
    tick_cause[2] = count_inc[16];
    tick_cause[1] = ~count_inc[18];
    tick_cause[0] = count_inc[18];
    tick_cause[8] = irq_line;
  end

  // Entry is checked against the freshly updated cause bits.
  assign taken = (func == FuncTick) && !stall && (status_q != 32'd0) &&
                 ((tick_cause & mask_q) != 32'd0);

  always_comb begin
    count_d  = count_q;
    cmpa_d   = cmpa_q;
    cmpb_d   = cmpb_q;
    cause_d  = cause_q;
    mask_d   = mask_q;
    status_d = status_q;
    epc_d    = epc_q;
    vector_d = vector_q;
    line_d   = line_q;
    res      = '0;
    unique case (func)
      FuncTick: begin
        count_d = count_inc;
        cause_d = tick_cause;
        if (taken) begin
          epc_d    = npc;
          status_d = '0;
          for (int k = 0; k < STATUS_DELAY_DEPTH; k++) begin
            line_d[k] = '0;
          end
          res.irq_taken  = 1'b1;
          res.handler_pc = vector_q;
        end
      end
      FuncRead: begin
        unique case (sel)
          RegVector:   res.read_data = vector_q;
          RegCause:    res.read_data = cause_q | CauseForced;
          RegMask:     res.read_data = mask_q;
          RegStatus:   res.read_data = status_q;
          RegEpc:      res.read_data = epc_q;
          RegCounter:  res.read_data = count_q;
          RegCompare:  res.read_data = cmpa_q;
          RegCompare2: res.read_data = cmpb_q;
          default:     res.read_data = '0;
        endcase
      end
      FuncWrite: begin
        unique case (sel)
          RegVector: vector_d = wval;
          RegCause:  cause_d  = wval;
          RegMask:   mask_d   = wval;
          RegStatus: begin
            // Zero clears everything; any other value only enters at the tail.
            if (wval == 32'd0) begin
              status_d = '0;
              for (int k = 0; k < STATUS_DELAY_DEPTH; k++) begin
                line_d[k] = '0;
              end
            end else begin
              line_d[Tail] = wval;
            end
          end
          RegEpc:     epc_d   = wval;
          RegCounter: count_d = wval;
          RegCompare: begin
            cmpa_d  = wval;
            cause_d = cause_q & CmpaKeepMask;
          end
          RegCompare2: begin
            cmpb_d  = wval;
            cause_d = cause_q & CmpbKeepMask;
          end
          default: ;
        endcase
      end
      FuncRetire: begin
        status_d = line_q[0];
        for (int k = 0; k < STATUS_DELAY_DEPTH - 1; k++) begin
          line_d[k] = line_q[k+1];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      cmpa_q   <= '0;
      cmpb_q   <= '0;
      cause_q  <= '0;
      mask_q   <= '0;
      status_q <= '0;
      epc_q    <= '0;
      vector_q <= '0;
      for (int k = 0; k < STATUS_DELAY_DEPTH; k++) begin
        line_q[k] <= '0;
      end
    end else if (accept) begin
      count_q  <= count_d;
      cmpa_q   <= cmpa_d;
      cmpb_q   <= cmpb_d;
      cause_q  <= cause_d;
      mask_q   <= mask_d;
      status_q <= status_d;
      epc_q    <= epc_d;
      vector_q <= vector_d;
      line_q   <= line_d;
    end
  end

  itc_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (res),
    .ready_o     (s_axis_tready_o),
    .valid_o     (m_axis_tvalid_o),
    .pop_ready_i (m_axis_tready_i),
    .pop_data_o  (out_res)
  );

  assign m_axis_tdata_o = {out_res.handler_pc, out_res.read_data};
  assign m_axis_tuser_o = out_res.irq_taken;

  a_tick_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && func == FuncTick |=> count_q == $past(count_q) + 32'd1)
    else $error("counter did not advance on a tick");

  a_entry_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && taken |=> status_q == 32'd0 && line_q[0] == 32'd0 && epc_q == $past(npc))
    else $error("interrupt entry did not clear status or save pc");

  a_retire_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && func == FuncRetire |=> status_q == $past(line_q[0]))
    else $error("retire did not load status from the delay line");

  a_no_entry_disabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_q == 32'd0 |-> !taken)
    else $error("interrupt entry while status is clear");

endmodule

### sim/irq_timer_controller_tb.sv
module irq_timer_controller_tb;
  import itc_pkg::*;

  localparam int unsigned Depth       = StatusDelayDepthDef;
  localparam int unsigned RandomItems = 1550;
  localparam int unsigned IdleLimit   = 1000;
  localparam int unsigned DrainCycles = 8;

  typedef struct {
    func_e       func;
    reg_sel_e    sel;
    logic [31:0] write_value;
    logic        noc_irq;
    logic        stall_req;
    logic [31:0] next_pc;
    bit          hold;
  } itc_cmd_t;

  typedef struct {
    logic [31:0] read_data;
    logic        irq_taken;
    logic [31:0] handler_pc;
  } itc_out_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i  = '0;
  logic [InUserW-1:0]  s_axis_tuser_i  = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                m_axis_tuser_o;

  irq_timer_controller u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow copy of the controller state.
  logic [31:0] sh_count  = '0;
  logic [31:0] sh_cmp_a  = '0;
  logic [31:0] sh_cmp_b  = '0;
  logic [31:0] sh_cause  = '0;
  logic [31:0] sh_mask   = '0;
  logic [31:0] sh_status = '0;
  logic [31:0] sh_epc    = '0;
  logic [31:0] sh_vector = '0;
  logic [31:0] sh_line [Depth] = '{default: '0};

  itc_cmd_t cmd_q[$];
  itc_out_t result_q[$];
  itc_cmd_t cur_cmd;
  itc_out_t want;

  int n_errors  = 0;
  int n_checked = 0;
  int n_sent    = 0;
  int n_ticks   = 0;
  int n_entries = 0;
  int n_reads   = 0;
  int n_writes  = 0;
  int n_retires = 0;

  int unsigned burst_left  = 8;
  int unsigned gap_left    = 0;
  int unsigned rdy_mode    = 0;
  int unsigned mode_left   = 0;
  int unsigned phase_ctr   = 0;
  int unsigned idle_cycles = 0;

  function automatic itc_out_t apply_cmd(itc_cmd_t c);
    itc_out_t r;
    r = '{read_data: '0, irq_taken: 1'b0, handler_pc: '0};
    case (c.func)
      FuncTick: begin
        n_ticks++;
        sh_count = sh_count + 32'd1;
        if ((sh_cmp_b & CmpbMask) == (sh_count & CmpbMask)) sh_cause |= CauseCmpb;
        if (sh_cmp_a == sh_count) sh_cause |= CauseCmpa;
        // Phase bits track counter bits 16 and 18; bit 8 mirrors the external line.
        sh_cause[3] = ~sh_count[16];
        sh_cause[2] = sh_count[16];
        sh_cause[1] = ~sh_count[18];
        sh_cause[0] = sh_count[18];
        sh_cause[8] = c.noc_irq;
        if (!c.stall_req && sh_status != '0 && (sh_cause & sh_mask) != '0) begin
          n_entries++;
          sh_epc       = c.next_pc;
          sh_status    = '0;
          sh_line      = '{default: '0};
          r.irq_taken  = 1'b1;
          r.handler_pc = sh_vector;
        end
      end
      FuncRead: begin
        n_reads++;
        case (c.sel)
          RegVector:  r.read_data = sh_vector;
          RegCause:   r.read_data = sh_cause | CauseForced;
          RegMask:    r.read_data = sh_mask;
          RegStatus:  r.read_data = sh_status;
          RegEpc:     r.read_data = sh_epc;
          RegCounter: r.read_data = sh_count;
          RegCompare: r.read_data = sh_cmp_a;
          default:    r.read_data = sh_cmp_b;
        endcase
      end
      FuncWrite: begin
        n_writes++;
        case (c.sel)
          RegVector:  sh_vector = c.write_value;
          RegCause:   sh_cause  = c.write_value;
          RegMask:    sh_mask   = c.write_value;
          RegStatus: begin
            // Zero wipes the status and the whole line; anything else lands at the tail.
            if (c.write_value == '0) begin
              sh_status = '0;
              sh_line   = '{default: '0};
            end else begin
              sh_line[Depth-1] = c.write_value;
            end
          end
          RegEpc:     sh_epc   = c.write_value;
          RegCounter: sh_count = c.write_value;
          RegCompare: begin
            sh_cmp_a = c.write_value;
            sh_cause &= CmpaKeepMask;
          end
          default: begin
            sh_cmp_b = c.write_value;
            sh_cause &= CmpbKeepMask;
          end
        endcase
      end
      default: begin
        n_retires++;
        sh_status = sh_line[0];
        for (int k = 0; k < Depth - 1; k++) sh_line[k] = sh_line[k+1];
      end
    endcase
    return r;
  endfunction

  function automatic itc_cmd_t make_cmd(func_e f, reg_sel_e s, logic [31:0] v);
    itc_cmd_t c;
    c.func        = f;
    c.sel         = s;
    c.write_value = v;
    c.noc_irq     = 1'($urandom_range(0, 1));
    c.stall_req   = ($urandom_range(0, 3) == 0);
    c.next_pc     = $urandom;
    c.hold        = 1'b0;
    return c;
  endfunction

  // Sender: bursts of items separated by random gaps. An item marked hold waits
  // until every outstanding result has been returned.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      s_axis_tuser_i  <= '0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        result_q.push_back(apply_cmd(cur_cmd));
        n_sent++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid_i <= 1'b0;
        end else if (cmd_q.size() > 0 && (!cmd_q[0].hold || result_q.size() == 0)) begin
          cur_cmd = cmd_q.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= {6'd0, cur_cmd.next_pc, cur_cmd.stall_req, cur_cmd.noc_irq,
                              cur_cmd.write_value};
          s_axis_tuser_i  <= {cur_cmd.sel, cur_cmd.func};
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each returned item and back-pressures in changing modes.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        n_checked++;
        if (result_q.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result item data %h taken %b", $time,
                   m_axis_tdata_o, m_axis_tuser_o);
        end else begin
          want = result_q.pop_front();
          if (m_axis_tdata_o[31:0] !== want.read_data) begin
            n_errors++;
            $display("%0t: read_data expected %h actual %h", $time,
                     want.read_data, m_axis_tdata_o[31:0]);
          end
          if (m_axis_tuser_o !== want.irq_taken) begin
            n_errors++;
            $display("%0t: irq_taken expected %b actual %b", $time,
                     want.irq_taken, m_axis_tuser_o);
          end
          if (m_axis_tdata_o[63:32] !== want.handler_pc) begin
            n_errors++;
            $display("%0t: handler_pc expected %h actual %h", $time,
                     want.handler_pc, m_axis_tdata_o[63:32]);
          end
        end
      end
      if (mode_left == 0) begin
        rdy_mode  = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      phase_ctr++;
      case (rdy_mode)
        0:       m_axis_tready_i <= 1'b1;
        1:       m_axis_tready_i <= ($urandom_range(0, 9) < 7);
        2:       m_axis_tready_i <= ((phase_ctr % 7) >= 3);
        default: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
                 idle_cycles, result_q.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    itc_cmd_t    c;
    logic [31:0] base;
    logic [31:0] val;
    int unsigned target;
    int unsigned first;
    int unsigned seq_cnt;
    int unsigned bit_idx;

    // Counter wraps to zero with compare at zero and compare2 low bits at zero.
    cmd_q.push_back(make_cmd(FuncWrite, RegCounter, 32'hffff_ffff));
    cmd_q.push_back(make_cmd(FuncWrite, RegCompare2, 32'hff00_0000));
    c = make_cmd(FuncTick, RegVector, $urandom);
    c.stall_req = 1'b1;
    c.noc_irq   = 1'b1;
    cmd_q.push_back(c);
    cmd_q.push_back(make_cmd(FuncRead, RegCause, $urandom));
    cmd_q.push_back(make_cmd(FuncWrite, RegCause, 32'hffff_ffff));
    cmd_q.push_back(make_cmd(FuncWrite, RegCompare, 32'h0000_0000));
    cmd_q.push_back(make_cmd(FuncRead, RegCause, $urandom));
    cmd_q.push_back(make_cmd(FuncWrite, RegCompare2, 32'hffff_ffff));
    cmd_q.push_back(make_cmd(FuncWrite, RegMask, 32'hffff_ffff));
    cmd_q.push_back(make_cmd(FuncWrite, RegVector, 32'hffff_fffc));
    cmd_q.push_back(make_cmd(FuncWrite, RegStatus, 32'h0000_0001));
    for (int i = 0; i < Depth; i++) cmd_q.push_back(make_cmd(FuncRetire, RegStatus, $urandom));
    // A zero status write empties the line, so the next retire brings zero.
    cmd_q.push_back(make_cmd(FuncWrite, RegStatus, 32'h0000_0000));
    cmd_q.push_back(make_cmd(FuncRetire, RegStatus, $urandom));
    cmd_q.push_back(make_cmd(FuncRead, RegStatus, $urandom));
    cmd_q.push_back(make_cmd(FuncWrite, RegStatus, 32'hffff_ffff));
    for (int i = 0; i < Depth; i++) cmd_q.push_back(make_cmd(FuncRetire, RegStatus, $urandom));
    c = make_cmd(FuncTick, RegVector, $urandom);
    c.stall_req = 1'b1;
    cmd_q.push_back(c);
    c = make_cmd(FuncTick, RegVector, $urandom);
    c.stall_req = 1'b0;
    c.next_pc   = 32'hffff_ffff;
    cmd_q.push_back(c);
    cmd_q.push_back(make_cmd(FuncRead, RegEpc, $urandom));

    target  = cmd_q.size() + RandomItems;
    seq_cnt = 0;
    while (cmd_q.size() < target) begin
      first = cmd_q.size();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // Arm an interrupt: vector, mask, status through the line, then ticks.
          cmd_q.push_back(make_cmd(FuncWrite, RegVector, $urandom));
          case ($urandom_range(0, 3))
            0: val = $urandom;
            1: val = '0;
            default: begin
              bit_idx = $urandom_range(0, 6);
              if (bit_idx == 6) bit_idx = 8;
              val = 32'd1 << bit_idx;
            end
          endcase
          cmd_q.push_back(make_cmd(FuncWrite, RegMask, val));
          val = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom;
          cmd_q.push_back(make_cmd(FuncWrite, RegStatus, val));
          repeat ($urandom_range(1, Depth + 1)) begin
            if ($urandom_range(0, 2) == 0) begin
              cmd_q.push_back(make_cmd(FuncRead, reg_sel_e'($urandom_range(0, 7)), $urandom));
            end
            cmd_q.push_back(make_cmd(FuncRetire, reg_sel_e'($urandom_range(0, 7)), $urandom));
          end
          repeat ($urandom_range(1, 6)) begin
            cmd_q.push_back(make_cmd(FuncTick, reg_sel_e'($urandom_range(0, 7)), $urandom));
          end
          cmd_q.push_back(make_cmd(FuncRead, ($urandom_range(0, 1) == 0) ? RegEpc : RegStatus,
                                   $urandom));
        end
        4, 5: begin
          // Timer: start the counter near a phase or wrap boundary, or at random, and aim the compares.
          case ($urandom_range(0, 3))
            0:       base = 32'h0000_ffff - $urandom_range(0, 4);
            1:       base = 32'h0003_ffff - $urandom_range(0, 4);
            2:       base = 32'hffff_ffff - $urandom_range(0, 4);
            default: base = $urandom;
          endcase
          cmd_q.push_back(make_cmd(FuncWrite, RegCounter, base));
          val = ($urandom_range(0, 3) == 0) ? $urandom : base + $urandom_range(1, 6);
          cmd_q.push_back(make_cmd(FuncWrite, RegCompare, val));
          val = base + $urandom_range(1, 6);
          val[31:24] = 8'($urandom_range(0, 255));
          cmd_q.push_back(make_cmd(FuncWrite, RegCompare2, val));
          repeat ($urandom_range(1, 8)) begin
            cmd_q.push_back(make_cmd(FuncTick, reg_sel_e'($urandom_range(0, 7)), $urandom));
          end
          cmd_q.push_back(make_cmd(FuncRead, RegCause, $urandom));
          if ($urandom_range(0, 1) == 0) cmd_q.push_back(make_cmd(FuncRead, RegCounter, $urandom));
        end
        6: begin
          repeat ($urandom_range(1, 6)) begin
            cmd_q.push_back(make_cmd(FuncRead, reg_sel_e'($urandom_range(0, 7)), $urandom));
          end
        end
        default: begin
          repeat ($urandom_range(1, 8)) begin
            cmd_q.push_back(make_cmd(func_e'($urandom_range(0, 3)),
                                     reg_sel_e'($urandom_range(0, 7)), $urandom));
          end
        end
      endcase
      // Now and then the sender holds off until the result stream has drained.
      if (seq_cnt % 50 == 0) cmd_q[first].hold = 1'b1;
      seq_cnt++;
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    do @(negedge clk_i);
    while (cmd_q.size() != 0 || s_axis_tvalid_i || result_q.size() != 0);
    repeat (DrainCycles) @(negedge clk_i);

    $display("covered %0d items: %0d ticks with %0d interrupt entries,", n_sent, n_ticks,
             n_entries);
    $display("%0d reads, %0d writes, %0d retires; %0d result items checked, %0d mismatches",
             n_reads, n_writes, n_retires, n_checked, n_errors);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
